// File: hdl/ccp_pkg.sv
// types, constants and command/status records shared by the circle canvas painter
// no dependencies
`timescale 1ns / 1ps

package ccp_pkg;

   // fixed field widths
   localparam int FUNC_W    = 2;
   localparam int CENTER_W  = 20;
   localparam int RADIUS_W  = 19;
   localparam int COLOR_W   = 8;
   localparam int PIXPOS_W  = 8;
   localparam int DIMREG_W  = 9;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // parameter defaults
   localparam int MAX_DIM_DEF   = 256;
   localparam int FRAC_BITS_DEF = 8;

   // register reset values
   localparam logic [DIMREG_W-1:0] WIDTH_RST  = 9'd256;
   localparam logic [DIMREG_W-1:0] HEIGHT_RST = 9'd256;
   localparam logic [COLOR_W-1:0]  BG_RST     = 8'd32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_DRAW  = 2'd1,
      FUNC_READ  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_BG     = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic walk;
      logic mem_rd;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     r_zero;
      logic     dims_zero;
      logic     rd_in_range;
      logic     walk_last;
      logic     pipe_busy;
   } sts_type;

endpackage

// File: hdl/ccp_req_if.sv
// request channel of the circle canvas painter: valid/ready plus command payload
// depends on ccp_pkg
`timescale 1ns / 1ps

interface ccp_req_if;
   logic                                valid;
   logic                                ready;
   logic [ccp_pkg::FUNC_W-1:0]          func;
   logic signed [ccp_pkg::CENTER_W-1:0] center_x;
   logic signed [ccp_pkg::CENTER_W-1:0] center_y;
   logic [ccp_pkg::RADIUS_W-1:0]        radius;
   logic                                filled;
   logic [ccp_pkg::COLOR_W-1:0]         color;
   logic [ccp_pkg::PIXPOS_W-1:0]        pixel_x;
   logic [ccp_pkg::PIXPOS_W-1:0]        pixel_y;

   modport source (
      output valid, func, center_x, center_y, radius, filled, color, pixel_x, pixel_y,
      input  ready
   );
   modport sink (
      input  valid, func, center_x, center_y, radius, filled, color, pixel_x, pixel_y,
      output ready
   );
endinterface

// File: hdl/ccp_rsp_if.sv
// response channel of the circle canvas painter: valid/ready plus status and pixel
// depends on ccp_pkg
`timescale 1ns / 1ps

interface ccp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        status;
   logic [ccp_pkg::COLOR_W-1:0] pixel;

   modport source (
      output valid, status, pixel,
      input  ready
   );
   modport sink (
      input  valid, status, pixel,
      output ready
   );
endinterface

// File: hdl/ccp_csr.sv
// apb register block: canvas width, canvas height, background byte
// depends on ccp_pkg
`timescale 1ns / 1ps

module ccp_csr #(
   parameter int MAX_DIM = ccp_pkg::MAX_DIM_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ccp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [ccp_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ccp_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [$clog2(MAX_DIM+1)-1:0]    w_used,
   output logic [$clog2(MAX_DIM+1)-1:0]    h_used,
   output logic [ccp_pkg::COLOR_W-1:0]     background
);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int DR_W  = ccp_pkg::DIMREG_W;
   localparam int CW    = ccp_pkg::COLOR_W;
   localparam int DATA_W = ccp_pkg::CSR_DATA_W;

   logic [DR_W-1:0] width_ff, width_in;
   logic [DR_W-1:0] height_ff, height_in;
   logic [CW-1:0]   bg_ff, bg_in;
   logic            wr_en;
   ccp_pkg::reg_idx_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = ccp_pkg::reg_idx_type'(paddr[3:2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bg_in     = bg_ff;
      prdata    = '0;
      case (idx)
         ccp_pkg::REG_WIDTH: begin
            prdata = DATA_W'(width_ff);
            if (wr_en) width_in = pwdata[DR_W-1:0];
         end
         ccp_pkg::REG_HEIGHT: begin
            prdata = DATA_W'(height_ff);
            if (wr_en) height_in = pwdata[DR_W-1:0];
         end
         ccp_pkg::REG_BG: begin
            prdata = DATA_W'(bg_ff);
            if (wr_en) bg_in = pwdata[CW-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ccp_pkg::WIDTH_RST;
         height_ff <= ccp_pkg::HEIGHT_RST;
         bg_ff     <= ccp_pkg::BG_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         bg_ff     <= bg_in;
      end
   end

   // dimensions above the canvas size clamp to it
   assign w_used = (32'(width_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(width_ff);
   assign h_used = (32'(height_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(height_ff);
   assign background = bg_ff;

endmodule

// File: hdl/ccp_ctrl.sv
// controller state machine: sequences clear, draw and read requests
// depends on ccp_pkg
`timescale 1ns / 1ps

module ccp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  ccp_pkg::sts_type sts,
   output ccp_pkg::cmd_type cmd
);
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_SETUP  = 7'b0000100,
      ST_WALK   = 7'b0001000,
      ST_DRAIN  = 7'b0010000,
      ST_READ   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.func)
               ccp_pkg::FUNC_CLEAR: begin
                  state_in = sts.dims_zero ? ST_DONE : ST_WALK;
               end
               ccp_pkg::FUNC_DRAW: begin
                  state_in = (sts.r_zero || sts.dims_zero) ? ST_DONE : ST_SETUP;
               end
               ccp_pkg::FUNC_READ: begin
                  state_in = sts.rd_in_range ? ST_READ : ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) state_in = ST_DONE;
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/ccp_dpath.sv
// datapath: request capture, pixel walker, distance pipeline, canvas memory, response
// depends on ccp_pkg
`timescale 1ns / 1ps

module ccp_dpath #(
   parameter int MAX_DIM   = ccp_pkg::MAX_DIM_DEF,
   parameter int FRAC_BITS = ccp_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ccp_pkg::FUNC_W-1:0]          func,
   input  logic signed [ccp_pkg::CENTER_W-1:0] center_x,
   input  logic signed [ccp_pkg::CENTER_W-1:0] center_y,
   input  logic [ccp_pkg::RADIUS_W-1:0]        radius,
   input  logic                                filled,
   input  logic [ccp_pkg::COLOR_W-1:0]         color,
   input  logic [ccp_pkg::PIXPOS_W-1:0]        pixel_x,
   input  logic [ccp_pkg::PIXPOS_W-1:0]        pixel_y,
   input  logic [$clog2(MAX_DIM+1)-1:0]        w_used,
   input  logic [$clog2(MAX_DIM+1)-1:0]        h_used,
   input  logic [ccp_pkg::COLOR_W-1:0]         background,
   input  ccp_pkg::cmd_type                    cmd,
   output ccp_pkg::sts_type                    sts,
   output logic                                rsp_status,
   output logic [ccp_pkg::COLOR_W-1:0]         rsp_pixel
);
   localparam int CX_W   = ccp_pkg::CENTER_W;
   localparam int R_W    = ccp_pkg::RADIUS_W;
   localparam int CW     = ccp_pkg::COLOR_W;
   localparam int PP_W   = ccp_pkg::PIXPOS_W;
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int POS_W  = IDX_W + FRAC_BITS;
   localparam int DW     = ((POS_W + 1 > CX_W) ? POS_W + 1 : CX_W) + 1;
   localparam int SQ_W   = 2 * DW;
   localparam int SUM_W  = SQ_W + 1;
   localparam int RSQ_W  = 2 * R_W;
   localparam int CMP_W  = (DIM_W > PP_W) ? DIM_W : PP_W;
   localparam logic [R_W-1:0]   ONE = R_W'(1) << FRAC_BITS;
   localparam logic [SUM_W-1:0] FLOOR_MASK = (SUM_W'(1) << (2 * FRAC_BITS)) - SUM_W'(1);

   // captured request
   ccp_pkg::func_type      func_ff;
   logic signed [CX_W-1:0] cx_ff, cy_ff;
   logic [R_W-1:0]         r_ff, rm1_ff;
   logic                   r_zero_ff, has_inner_ff, filled_ff;
   logic [CW-1:0]          color_ff;
   logic [ADDR_W-1:0]      rd_addr_ff;
   logic                   rd_in_range_ff;

   // circle bounds
   logic [RSQ_W-1:0] outer_ff, inner_ff;

   // walker
   logic [IDX_W-1:0]  x_ff, y_ff;
   logic [ADDR_W-1:0] row_base_ff;
   logic [IDX_W-1:0]  x_last, y_last;

   // pipeline
   logic                 v1_ff, v2_ff, v3_ff;
   logic [ADDR_W-1:0]    addr1_ff, addr2_ff, addr3_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff;
   logic signed [SQ_W-1:0] sqx2_ff, sqy2_ff;
   logic [SUM_W-1:0]     sum3_ff;
   logic signed [DW-1:0] pos_x, pos_y;
   logic [SUM_W-1:0]     s_floor;
   logic                 covered, interior, wr_en;
   logic [CW-1:0]        wr_data;

   // memory and response
   logic [CW-1:0] canvas_mem [MEM_DEPTH];
   logic [CW-1:0] rd_data_ff;
   logic          status_ff, status_in;
   logic [CW-1:0] pixel_ff, pixel_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff        <= ccp_pkg::func_type'(func);
         cx_ff          <= center_x;
         cy_ff          <= center_y;
         r_ff           <= radius;
         rm1_ff         <= radius - ONE;
         r_zero_ff      <= (radius == '0);
         has_inner_ff   <= (radius >= ONE);
         filled_ff      <= filled;
         color_ff       <= color;
         rd_addr_ff     <= ADDR_W'(32'(pixel_y) * MAX_DIM + 32'(pixel_x));
         rd_in_range_ff <= (CMP_W'(pixel_x) < CMP_W'(w_used)) &&
                           (CMP_W'(pixel_y) < CMP_W'(h_used));
      end
      if (cmd.setup) begin
         outer_ff <= r_ff * r_ff;
         inner_ff <= rm1_ff * rm1_ff;
      end
   end

   // raster walk, one pixel per cycle
   assign x_last = IDX_W'(w_used - DIM_W'(1));
   assign y_last = IDX_W'(h_used - DIM_W'(1));

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         x_ff        <= '0;
         y_ff        <= '0;
         row_base_ff <= '0;
      end else if (cmd.walk) begin
         if (x_ff == x_last) begin
            x_ff        <= '0;
            y_ff        <= y_ff + IDX_W'(1);
            row_base_ff <= row_base_ff + ADDR_W'(MAX_DIM);
         end else begin
            x_ff <= x_ff + IDX_W'(1);
         end
      end
   end

   assign pos_x = DW'(x_ff) << FRAC_BITS;
   assign pos_y = DW'(y_ff) << FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.walk;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      addr1_ff <= row_base_ff + ADDR_W'(x_ff);
      dx1_ff   <= pos_x - DW'(cx_ff);
      dy1_ff   <= pos_y - DW'(cy_ff);
      addr2_ff <= addr1_ff;
      sqx2_ff  <= dx1_ff * dx1_ff;
      sqy2_ff  <= dy1_ff * dy1_ff;
      addr3_ff <= addr2_ff;
      sum3_ff  <= SUM_W'($unsigned(sqx2_ff)) + SUM_W'($unsigned(sqy2_ff));
   end

   // floor to whole pixel units, then exact ring / disc test
   assign s_floor  = sum3_ff & ~FLOOR_MASK;
   assign covered  = (s_floor <= SUM_W'(outer_ff));
   assign interior = has_inner_ff && (s_floor <= SUM_W'(inner_ff));
   assign wr_en    = v3_ff && ((func_ff == ccp_pkg::FUNC_CLEAR) ||
                               (covered && (!interior || filled_ff)));
   assign wr_data  = (func_ff == ccp_pkg::FUNC_CLEAR) ? background : color_ff;

   always_ff @(posedge clock) begin
      if (wr_en) canvas_mem[addr3_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) rd_data_ff <= canvas_mem[rd_addr_ff];
   end

   always_comb begin
      pixel_in = '0;
      case (func_ff)
         ccp_pkg::FUNC_CLEAR: begin
            status_in = 1'b0;
         end
         ccp_pkg::FUNC_DRAW: begin
            status_in = r_zero_ff;
         end
         ccp_pkg::FUNC_READ: begin
            status_in = !rd_in_range_ff;
            if (rd_in_range_ff) pixel_in = rd_data_ff;
         end
         default: begin
            status_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         status_ff <= status_in;
         pixel_ff  <= pixel_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_pixel  = pixel_ff;

   assign sts.func        = func_ff;
   assign sts.r_zero      = r_zero_ff;
   assign sts.dims_zero   = (w_used == '0) || (h_used == '0);
   assign sts.rd_in_range = rd_in_range_ff;
   assign sts.walk_last   = (x_ff == x_last) && (y_ff == y_last);
   assign sts.pipe_busy   = v1_ff || v2_ff || v3_ff;

endmodule

// File: hdl/circle_canvas_painter.sv
// top level of the circle canvas painter: registers, controller and datapath
// depends on ccp_pkg, ccp_req_if, ccp_rsp_if, ccp_csr, ccp_ctrl, ccp_dpath
`timescale 1ns / 1ps

// usage
//   req_chan carries one request: clear, draw circle or read pixel. it is
//   taken when valid and ready are high together; ready is high while the
//   block is idle, also while an earlier response still waits in rsp_chan.
//   rsp_chan returns one response per request: status (1 = rejected) and
//   the pixel byte for a read. the response register holds it until taken.
//   the apb port sets canvas width, height and background between requests.
// sequencing, from acceptance to the raise of rsp_chan.valid
//   clear walks every canvas pixel; draw sets up the circle, then walks every
//   pixel; both then drain the pipeline. zero radius, rejected read, unused
//   code or empty canvas skip to the response; a read first reads the memory.
//   the raster walker visits one pixel per cycle, which bounds clear/draw;
//   the next request can be taken in the cycle after the response is loaded
// reset
//   synchronous; registers return to 256 x 256 and background 32, the
//   canvas contents stay undefined until the first clear.
// stalls
//   a held response blocks only the completion of the next request; that
//   request is accepted and worked on meanwhile.

module circle_canvas_painter #(
   parameter int MAX_DIM   = ccp_pkg::MAX_DIM_DEF,
   parameter int FRAC_BITS = ccp_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   ccp_req_if.sink                        req_chan,
   ccp_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ccp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ccp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ccp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   localparam int DIM_W = $clog2(MAX_DIM + 1);

   // clamped canvas size and background from the register block
   logic [DIM_W-1:0]            w_used, h_used;
   logic [ccp_pkg::COLOR_W-1:0] background;

   // controller <-> datapath
   ccp_pkg::cmd_type cmd;
   ccp_pkg::sts_type sts;

   ccp_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .w_used     (w_used),
      .h_used     (h_used),
      .background (background)
   );

   // sequencing: idle, decode, circle setup, raster walk, drain, read, respond
   ccp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // request capture, distance pipeline, canvas memory and response register
   ccp_dpath #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .func       (req_chan.func),
      .center_x   (req_chan.center_x),
      .center_y   (req_chan.center_y),
      .radius     (req_chan.radius),
      .filled     (req_chan.filled),
      .color      (req_chan.color),
      .pixel_x    (req_chan.pixel_x),
      .pixel_y    (req_chan.pixel_y),
      .w_used     (w_used),
      .h_used     (h_used),
      .background (background),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_status (rsp_chan.status),
      .rsp_pixel  (rsp_chan.pixel)
   );

`ifndef SYNTHESIS
   // one request at a time: ready drops straight after a request is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another was in flight");

   // a new response never overwrites one still waiting
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("response register overwritten");

   // all canvas writes of the previous request have drained before a new one
   a_pipe_empty_on_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !sts.pipe_busy)
      else $error("request taken with pixel pipeline busy");

   // only clear and draw walk the canvas
   a_walk_func: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (sts.func == ccp_pkg::FUNC_CLEAR || sts.func == ccp_pkg::FUNC_DRAW))
      else $error("raster walk for a request that does not paint");
`endif

endmodule
